/* rtl/qdfl_pkg.sv */
`timescale 1ns / 1ps

package qdfl_pkg;

   // field widths
   localparam int STAMP_BITS   = 48;
   localparam int FPS_BITS     = 8;
   localparam int TICK_BITS    = 8;
   localparam int DWELL_BITS   = 16;
   localparam int QUAL_BITS    = 2;
   localparam int FEC_BITS     = 6;
   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;
   localparam int REG_IDX_BITS = 3;

   localparam int TIME_BITS_DEFAULT = 48;

   // ladder: 1, 2/3, 1/2, 2/5, 1/3 of the configured rate
   localparam int RUNG_COUNT = 5;

   // quality levels
   localparam logic [QUAL_BITS-1:0] QUAL_GOOD = 2'd0;
   localparam logic [QUAL_BITS-1:0] QUAL_FAIR = 2'd1;
   localparam logic [QUAL_BITS-1:0] QUAL_POOR = 2'd2;
   localparam logic [QUAL_BITS-1:0] QUAL_BAD  = 2'd3;

   localparam logic [FEC_BITS-1:0] FEC_POOR  = 6'd50;
   localparam logic [FEC_BITS-1:0] FEC_BAD   = 6'd30;
   localparam logic [FEC_BITS-1:0] FEC_OTHER = 6'd40;

   // register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_FPS       = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MIN_FPS   = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_DOWN_TICK = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_UP_TICK   = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_DWELL     = 3'd4;

   // register reset values
   localparam logic [FPS_BITS-1:0]   FPS_RESET       = 8'd30;
   localparam logic [FPS_BITS-1:0]   MIN_FPS_RESET   = 8'd10;
   localparam logic [TICK_BITS-1:0]  DOWN_TICK_RESET = 8'd2;
   localparam logic [TICK_BITS-1:0]  UP_TICK_RESET   = 8'd5;
   localparam logic [DWELL_BITS-1:0] DWELL_RESET     = 16'd2000;

   typedef struct packed {
      logic [FPS_BITS-1:0]   fps;
      logic [FPS_BITS-1:0]   min_fps;
      logic [TICK_BITS-1:0]  down_ticks;
      logic [TICK_BITS-1:0]  up_ticks;
      logic [DWELL_BITS-1:0] dwell_ms;
   } cfg_type;

   typedef struct packed {
      logic                load;
      logic [FPS_BITS-1:0] value;
   } fps_load_type;

   typedef logic [RUNG_COUNT-1:0][FPS_BITS-1:0] rung_array_type;

   typedef struct packed {
      logic [QUAL_BITS-1:0]  level;
      logic [FPS_BITS-1:0]   fps;
      logic [FEC_BITS-1:0]   fec;
      logic [STAMP_BITS-1:0] age;
      logic                  keyframe;
   } result_type;

   // x / 6 for x < 1024
   function automatic logic [FPS_BITS-1:0] div6(input logic [10:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[19:12];
   endfunction

   // x / 10 for x < 2048 (used up to 1025)
   function automatic logic [FPS_BITS-1:0] div10(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd3277;
      return p[22:15];
   endfunction

   // rounded rung before the floor clamp
   function automatic logic [FPS_BITS-1:0] rung_value(input logic [FPS_BITS-1:0] f,
                                                      input int k);
      logic [10:0] fx;
      logic [FPS_BITS-1:0] v;
      fx = 11'(f);
      case (k)
         0: v = f;
         1: v = div6((fx << 2) + 11'd3);
         2: v = 8'((fx + 11'd1) >> 1);
         3: v = div10((fx << 2) + 11'd5);
         default: v = div6((fx << 1) + 11'd3);
      endcase
      return v;
   endfunction

endpackage

/* rtl/qdfl_csr.sv */
`timescale 1ns / 1ps

module qdfl_csr import qdfl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg,
   output fps_load_type         fps_load
);

   cfg_type cfg_ff, cfg_in;
   logic wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FPS:       cfg_in.fps        = pwdata[FPS_BITS-1:0];
            REG_MIN_FPS:   cfg_in.min_fps    = pwdata[FPS_BITS-1:0];
            REG_DOWN_TICK: cfg_in.down_ticks = pwdata[TICK_BITS-1:0];
            REG_UP_TICK:   cfg_in.up_ticks   = pwdata[TICK_BITS-1:0];
            REG_DWELL:     cfg_in.dwell_ms   = pwdata[DWELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fps        <= FPS_RESET;
         cfg_ff.min_fps    <= MIN_FPS_RESET;
         cfg_ff.down_ticks <= DOWN_TICK_RESET;
         cfg_ff.up_ticks   <= UP_TICK_RESET;
         cfg_ff.dwell_ms   <= DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FPS:       prdata = DATA_BITS'(cfg_ff.fps);
         REG_MIN_FPS:   prdata = DATA_BITS'(cfg_ff.min_fps);
         REG_DOWN_TICK: prdata = DATA_BITS'(cfg_ff.down_ticks);
         REG_UP_TICK:   prdata = DATA_BITS'(cfg_ff.up_ticks);
         REG_DWELL:     prdata = DATA_BITS'(cfg_ff.dwell_ms);
         default:       prdata = '0;
      endcase
   end

   assign cfg            = cfg_ff;
   assign fps_load.load  = wr_en && (reg_idx == REG_FPS);
   assign fps_load.value = pwdata[FPS_BITS-1:0];

endmodule

/* rtl/qdfl_ladder.sv */
`timescale 1ns / 1ps

// Rungs are rebuilt from the registers every cycle. Equal neighbors are left in
// place: a repeated value behaves like the single kept rung in every search.
module qdfl_ladder import qdfl_pkg::*; (
   input  logic                clock,
   input  cfg_type             cfg,
   output rung_array_type      rungs,
   output logic [FPS_BITS-1:0] poor_want
);

   rung_array_type rung_ff, rung_in;
   logic [FPS_BITS-1:0] want_ff, want_in;
   logic [FPS_BITS-1:0] half_fps;

   always_comb begin
      for (int k = 0; k < RUNG_COUNT; k++) begin
         rung_in[k] = rung_value(cfg.fps, k);
         if (rung_in[k] < cfg.min_fps) begin
            rung_in[k] = cfg.min_fps;
         end
      end
   end

   assign half_fps = cfg.fps >> 1;
   assign want_in  = (half_fps < cfg.min_fps) ? cfg.min_fps : half_fps;

   always_ff @(posedge clock) begin
      rung_ff <= rung_in;
      want_ff <= want_in;
   end

   assign rungs     = rung_ff;
   assign poor_want = want_ff;

endmodule

/* rtl/qdfl_core.sv */
`timescale 1ns / 1ps

module qdfl_core import qdfl_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  cfg_type               cfg,
   input  fps_load_type          fps_load,
   input  rung_array_type        rungs,
   input  logic [FPS_BITS-1:0]   poor_want,
   input  logic [QUAL_BITS-1:0]  raw_quality,
   input  logic [STAMP_BITS-1:0] now_ms,
   output result_type            result
);

   logic [QUAL_BITS-1:0]  level_ff, level_in;
   logic [QUAL_BITS-1:0]  cand_ff, cand_in;
   logic [TICK_BITS-1:0]  streak_ff, streak_in;
   logic [FPS_BITS-1:0]   fps_ff, fps_in;
   logic [TIME_BITS-1:0]  move_ff, move_in;
   logic [TIME_BITS-1:0]  start_ff, start_in;

   logic [TIME_BITS+STAMP_BITS-1:0] now_wide;
   logic [TIME_BITS+STAMP_BITS-1:0] age_wide;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] age_t;
   logic [TIME_BITS-1:0] since_move;
   logic keyframe;

   assign now_wide   = {{TIME_BITS{1'b0}}, now_ms};
   assign now_t      = now_wide[TIME_BITS-1:0];
   assign since_move = now_t - move_ff;

   // debounce
   always_comb begin
      logic [TICK_BITS-1:0] needed;
      level_in  = level_ff;
      cand_in   = cand_ff;
      streak_in = streak_ff;
      start_in  = start_ff;
      keyframe  = 1'b0;
      needed    = '0;
      if (raw_quality != level_ff) begin
         if (raw_quality == cand_ff) begin
            if (streak_ff != {TICK_BITS{1'b1}}) begin
               streak_in = streak_ff + 1'b1;
            end
         end else begin
            cand_in   = raw_quality;
            streak_in = TICK_BITS'(1);
         end
         needed = (raw_quality > level_ff) ? cfg.down_ticks : cfg.up_ticks;
         if (streak_in >= needed) begin
            level_in  = raw_quality;
            streak_in = '0;
            start_in  = now_t;
            keyframe  = (raw_quality == QUAL_BAD);
         end
      end else begin
         cand_in   = level_ff;
         streak_in = '0;
      end
   end

   // ladder moves, using the level after debounce
   always_comb begin
      logic [FPS_BITS-1:0] want;
      logic                jump_hit;
      logic [FPS_BITS-1:0] jump_fps;
      logic                on_ladder_below_top;
      logic [FPS_BITS-1:0] climb_fps;
      fps_in              = fps_ff;
      move_in             = move_ff;
      want                = (level_in == QUAL_BAD) ? rungs[RUNG_COUNT-1] : poor_want;
      jump_hit            = 1'b0;
      jump_fps            = '0;
      on_ladder_below_top = 1'b0;
      climb_fps           = '0;
      // descending scans leave the first match in front
      for (int k = RUNG_COUNT - 1; k >= 0; k--) begin
         if (rungs[k] <= want && rungs[k] < fps_ff) begin
            jump_hit = 1'b1;
            jump_fps = rungs[k];
         end
      end
      for (int k = RUNG_COUNT - 1; k >= 0; k--) begin
         if (rungs[k] == fps_ff) begin
            on_ladder_below_top = (k != 0);
            climb_fps           = (k != 0) ? rungs[(k == 0) ? 0 : k - 1] : '0;
         end
      end
      if (level_in == QUAL_POOR || level_in == QUAL_BAD) begin
         if (jump_hit) begin
            fps_in  = jump_fps;
            move_in = now_t;
         end
      end else if (on_ladder_below_top && since_move >= TIME_BITS'(cfg.dwell_ms)) begin
         fps_in  = climb_fps;
         move_in = now_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= QUAL_GOOD;
         cand_ff   <= QUAL_GOOD;
         streak_ff <= '0;
         fps_ff    <= FPS_RESET;
         move_ff   <= '0;
         start_ff  <= '0;
      end else if (fps_load.load) begin
         fps_ff <= fps_load.value;
      end else if (fire) begin
         level_ff  <= level_in;
         cand_ff   <= cand_in;
         streak_ff <= streak_in;
         fps_ff    <= fps_in;
         move_ff   <= move_in;
         start_ff  <= start_in;
      end
   end

   assign age_t    = now_t - start_in;
   assign age_wide = {{STAMP_BITS{1'b0}}, age_t};

   always_comb begin
      result.level    = level_in;
      result.fps      = fps_in;
      case (level_in)
         QUAL_POOR: result.fec = FEC_POOR;
         QUAL_BAD:  result.fec = FEC_BAD;
         default:   result.fec = FEC_OTHER;
      endcase
      result.age      = age_wide[STAMP_BITS-1:0];
      result.keyframe = keyframe;
   end

endmodule

/* rtl/quality_debounce_fps_ladder.sv */
`timescale 1ns / 1ps

// Accepted transactions pass from the input register to the result register.
// Throughput: one transaction per cycle unless rsp_stall holds a pending result;
// the debounce and ladder update for a tick is a single pass of logic between the
// input and result registers; rsp_valid marks a loaded result register.
// Reset (synchronous): control registers take defaults, level good, rate 30 fps.
module quality_debounce_fps_ladder import qdfl_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [QUAL_BITS-1:0]  req_raw_quality,
   input  logic [STAMP_BITS-1:0] req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [QUAL_BITS-1:0]  rsp_quality_level,
   output logic [FPS_BITS-1:0]   rsp_target_fps,
   output logic [FEC_BITS-1:0]   rsp_fec_cap_pct,
   output logic [STAMP_BITS-1:0] rsp_level_age_ms,
   output logic                  rsp_request_keyframe,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   cfg_type             cfg;
   fps_load_type        fps_load;
   rung_array_type      rungs;
   logic [FPS_BITS-1:0] poor_want;
   result_type          result;

   logic                  in_valid_ff, in_valid_in;
   logic [QUAL_BITS-1:0]  in_raw_ff;
   logic [STAMP_BITS-1:0] in_now_ff;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff;
   logic                  accept;
   logic                  advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_raw_ff <= req_raw_quality;
         in_now_ff <= req_now_ms;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   qdfl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .fps_load (fps_load)
   );

   qdfl_ladder u_ladder (
      .clock     (clock),
      .cfg       (cfg),
      .rungs     (rungs),
      .poor_want (poor_want)
   );

   qdfl_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .cfg         (cfg),
      .fps_load    (fps_load),
      .rungs       (rungs),
      .poor_want   (poor_want),
      .raw_quality (in_raw_ff),
      .now_ms      (in_now_ff),
      .result      (result)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_quality_level    = out_ff.level;
   assign rsp_target_fps       = out_ff.fps;
   assign rsp_fec_cap_pct      = out_ff.fec;
   assign rsp_level_age_ms     = out_ff.age;
   assign rsp_request_keyframe = out_ff.keyframe;

endmodule
